// ===== rtl/core/ckmc_pkg.sv =====
// Shared types, codes and constants for the color key mask and centroid block.
// Used by ckmc_match, color_key_mask_centroid and ckmc_checker; depends on nothing else.
package ckmc_pkg;

    localparam int CHAN_W          = 8;
    localparam int IDX_PORT_W      = 6;
    localparam int COORD_W         = 10;
    localparam int COUNT_W         = 21;
    localparam int CFG_DATA_W      = 8;
    localparam int COLORS_W        = 7;
    localparam int MAX_COLORS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 10;

    localparam logic [CHAN_W-1:0]   THRESHOLD_RESET = 8'd10;
    localparam logic [COLORS_W-1:0] COLORS_RESET    = 7'd0;
    localparam logic [COUNT_W-1:0]  TOTAL_MAX       = 21'h1F_FFFF;

    // request codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // configuration register indexes
    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_COLORS    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } color_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACCUM,
        ST_DIV_ROW,
        ST_WAIT_ROW,
        ST_DIV_COL,
        ST_WAIT_COL,
        ST_FINISH
    } ckmc_state_t;

endpackage

// ===== rtl/core/ckmc_match.sv =====
// Reference color table and serial compare unit: one table entry per cycle.
// Depends on ckmc_pkg.
module ckmc_match #(
    parameter int MAX_COLORS = ckmc_pkg::MAX_COLORS_DEF,
    parameter int IDX_W      = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1,
    parameter int CNT_W      = $clog2(MAX_COLORS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [IDX_W-1:0]                    wr_addr,
    input  ckmc_pkg::color_t                    wr_color,
    input  logic                                start,
    input  ckmc_pkg::color_t                    pixel,
    input  logic [ckmc_pkg::CHAN_W-1:0]         threshold,
    input  logic [ckmc_pkg::COLORS_W-1:0]       colors_in_use,
    output ckmc_pkg::scan_status_t              status
);

    ckmc_pkg::color_t mem [MAX_COLORS];
    ckmc_pkg::color_t rd_data_reg;
    ckmc_pkg::color_t pixel_reg;
    logic             active_reg;
    logic             rd_valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] n_eff;
    logic             issue;
    logic             match;

    // |px - ref| < t is the same as ref - t < px < ref + t
    function automatic logic near_channel(
        input logic [ckmc_pkg::CHAN_W-1:0] px,
        input logic [ckmc_pkg::CHAN_W-1:0] ref_val,
        input logic [ckmc_pkg::CHAN_W-1:0] t
    );
        logic [ckmc_pkg::CHAN_W:0] diff;
        logic [ckmc_pkg::CHAN_W:0] mag;
        diff = {1'b0, px} - {1'b0, ref_val};
        mag  = diff[ckmc_pkg::CHAN_W] ? (~diff + 1'b1) : diff;
        return mag < {1'b0, t};
    endfunction

    always_comb
    begin
        if (int'(colors_in_use) > MAX_COLORS)
            n_eff = CNT_W'(MAX_COLORS);
        else
            n_eff = CNT_W'(colors_in_use);
    end

    assign issue = active_reg && (cnt_reg != n_eff);
    assign match = rd_valid_reg
                   && near_channel(pixel_reg.blue,  rd_data_reg.blue,  threshold)
                   && near_channel(pixel_reg.green, rd_data_reg.green, threshold)
                   && near_channel(pixel_reg.red,   rd_data_reg.red,   threshold);

    // stop on the first hit, or once the entry last read has been compared
    assign status.done = active_reg && (match || (cnt_reg == n_eff));
    assign status.hit  = match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_color;
        if (issue)
            rd_data_reg <= mem[cnt_reg[IDX_W-1:0]];
        if (start)
            pixel_reg <= pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (start)
        begin
            active_reg   <= 1'b1;
            rd_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (status.done)
        begin
            active_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (issue)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/core/ckmc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the centroid mean.
// Depends on nothing beyond its parameters.
module ckmc_div #(
    parameter int QW = 10,
    parameter int DW = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QW+DW-1:0] dividend,
    input  logic [DW-1:0]    divisor,
    output logic             done,
    output logic [QW-1:0]    quotient
);

    localparam int STEP_W = $clog2(QW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     divisor_reg;
    logic [QW-1:0]     low_reg;
    logic [DW:0]       trial;
    logic              ge;

    // quotient fits in QW bits, so the top DW bits start below the divisor
    assign trial = {rem_reg, low_reg[QW-1]} - {1'b0, divisor_reg};
    assign ge    = !trial[DW];

    assign done     = done_reg;
    assign quotient = low_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= dividend[QW+DW-1:QW];
            low_reg     <= dividend[QW-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[DW-1:0] : {rem_reg[DW-2:0], low_reg[QW-1]};
            low_reg <= {low_reg[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/color_key_mask_centroid.sv =====
// Color key mask and centroid: a load request writes one reference color into
// the table if entry_index is below MAX_COLORS; a pixel request is compared
// against entries 0..n-1 one per cycle (n = colors_in_use, capped at
// MAX_COLORS) and stops at the first hit. The single table read port sets the
// pace of the compare, and ready returns with the result. The last pixel of a
// frame with at least one counted pixel adds two passes through the shared
// serial divider. A finished result waits in the output register while the next
// request is taken; a new result waits for it to leave.
// Depends on ckmc_pkg, ckmc_match and ckmc_div.
module color_key_mask_centroid #(
    parameter int MAX_COLORS = ckmc_pkg::MAX_COLORS_DEF,
    parameter int COORD_BITS = ckmc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [ckmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                mode,
    input  logic [ckmc_pkg::IDX_PORT_W-1:0]     entry_index,
    input  logic [ckmc_pkg::CHAN_W-1:0]         blue,
    input  logic [ckmc_pkg::CHAN_W-1:0]         green,
    input  logic [ckmc_pkg::CHAN_W-1:0]         red,
    input  logic [ckmc_pkg::COORD_W-1:0]        row,
    input  logic [ckmc_pkg::COORD_W-1:0]        col,
    input  logic                                last_of_frame,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic                                mask,
    output logic                                frame_done,
    output logic [ckmc_pkg::COORD_W-1:0]        centroid_row,
    output logic [ckmc_pkg::COORD_W-1:0]        centroid_col,
    output logic [ckmc_pkg::COUNT_W-1:0]        pixel_count
);

    localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int CW    = (COORD_BITS < ckmc_pkg::COORD_W) ? COORD_BITS
                                                              : ckmc_pkg::COORD_W;
    localparam int SUM_W = CW + ckmc_pkg::COUNT_W;

    ckmc_pkg::ckmc_state_t state_reg, state_next;

    logic [ckmc_pkg::CHAN_W-1:0]   threshold_reg;
    logic [ckmc_pkg::COLORS_W-1:0] colors_reg;

    logic [CW-1:0]                 row_reg;
    logic [CW-1:0]                 col_reg;
    logic                          last_reg;
    logic                          mask_reg;
    logic [SUM_W-1:0]              row_sum_reg;
    logic [SUM_W-1:0]              col_sum_reg;
    logic [ckmc_pkg::COUNT_W-1:0]  total_reg;
    logic [CW-1:0]                 cent_row_reg;
    logic [CW-1:0]                 cent_col_reg;

    logic                          res_valid_reg;
    logic                          res_mask_reg;
    logic                          res_done_reg;
    logic [CW-1:0]                 res_row_reg;
    logic [CW-1:0]                 res_col_reg;
    logic [ckmc_pkg::COUNT_W-1:0]  res_count_reg;

    logic                          accept;
    logic                          wr_en;
    logic                          scan_start;
    logic                          add_ok;
    logic                          div_start;
    logic [SUM_W-1:0]              div_dividend;
    logic                          div_done;
    logic [CW-1:0]                 div_quot;
    logic                          finish_fire;
    ckmc_pkg::color_t              in_color;
    ckmc_pkg::scan_status_t        scan;

    assign accept   = req_valid && req_ready;
    assign in_color = '{blue: blue, green: green, red: red};
    assign wr_en    = accept && (mode == ckmc_pkg::MODE_LOAD)
                      && (int'(entry_index) < MAX_COLORS);
    // a match counts only while the total is below saturation
    assign add_ok   = mask_reg && (total_reg != ckmc_pkg::TOTAL_MAX);

    ckmc_match #(
        .MAX_COLORS (MAX_COLORS),
        .IDX_W      (IDX_W)
    ) u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (IDX_W'(entry_index)),
        .wr_color      (in_color),
        .start         (scan_start),
        .pixel         (in_color),
        .threshold     (threshold_reg),
        .colors_in_use (colors_reg),
        .status        (scan)
    );

    ckmc_div #(
        .QW (CW),
        .DW (ckmc_pkg::COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ckmc_pkg::ST_IDLE:
                if (accept)
                    state_next = (mode == ckmc_pkg::MODE_PIXEL) ? ckmc_pkg::ST_SCAN
                                                                : ckmc_pkg::ST_FINISH;
            ckmc_pkg::ST_SCAN:
                if (scan.done)
                    state_next = ckmc_pkg::ST_ACCUM;
            ckmc_pkg::ST_ACCUM:
                if (last_reg && ((total_reg != '0) || add_ok))
                    state_next = ckmc_pkg::ST_DIV_ROW;
                else
                    state_next = ckmc_pkg::ST_FINISH;
            ckmc_pkg::ST_DIV_ROW:
                state_next = ckmc_pkg::ST_WAIT_ROW;
            ckmc_pkg::ST_WAIT_ROW:
                if (div_done)
                    state_next = ckmc_pkg::ST_DIV_COL;
            ckmc_pkg::ST_DIV_COL:
                state_next = ckmc_pkg::ST_WAIT_COL;
            ckmc_pkg::ST_WAIT_COL:
                if (div_done)
                    state_next = ckmc_pkg::ST_FINISH;
            ckmc_pkg::ST_FINISH:
                if (finish_fire)
                    state_next = ckmc_pkg::ST_IDLE;
            default:
                state_next = ckmc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_ready    = (state_reg == ckmc_pkg::ST_IDLE);
        scan_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = row_sum_reg;
        finish_fire  = 1'b0;
        unique case (state_reg)
            ckmc_pkg::ST_IDLE:
                scan_start = req_valid && (mode == ckmc_pkg::MODE_PIXEL);
            ckmc_pkg::ST_DIV_ROW:
                div_start = 1'b1;
            ckmc_pkg::ST_DIV_COL:
            begin
                div_start    = 1'b1;
                div_dividend = col_sum_reg;
            end
            ckmc_pkg::ST_FINISH:
                finish_fire = !res_valid_reg || res_ready;
            default:
                finish_fire = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ckmc_pkg::ST_IDLE;
            threshold_reg <= ckmc_pkg::THRESHOLD_RESET;
            colors_reg    <= ckmc_pkg::COLORS_RESET;
            row_sum_reg   <= '0;
            col_sum_reg   <= '0;
            total_reg     <= '0;
            cent_row_reg  <= '0;
            cent_col_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (ckmc_pkg::cfg_reg_t'(cfg_index))
                    ckmc_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                    ckmc_pkg::REG_COLORS:    colors_reg <= cfg_data[ckmc_pkg::COLORS_W-1:0];
                endcase
            end

            if ((state_reg == ckmc_pkg::ST_ACCUM) && add_ok)
            begin
                row_sum_reg <= row_sum_reg + SUM_W'(row_reg);
                col_sum_reg <= col_sum_reg + SUM_W'(col_reg);
                total_reg   <= total_reg + 1'b1;
            end

            if ((state_reg == ckmc_pkg::ST_WAIT_ROW) && div_done)
                cent_row_reg <= div_quot;
            if ((state_reg == ckmc_pkg::ST_WAIT_COL) && div_done)
                cent_col_reg <= div_quot;

            // clear the frame sums once the frame result is out
            if (finish_fire && last_reg)
            begin
                row_sum_reg <= '0;
                col_sum_reg <= '0;
                total_reg   <= '0;
            end

            if (finish_fire)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // request payload and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg  <= row[CW-1:0];
            col_reg  <= col[CW-1:0];
            last_reg <= (mode == ckmc_pkg::MODE_PIXEL) && last_of_frame;
            mask_reg <= 1'b0;
        end
        if ((state_reg == ckmc_pkg::ST_SCAN) && scan.done)
            mask_reg <= scan.hit;

        if (finish_fire)
        begin
            res_mask_reg  <= mask_reg;
            res_done_reg  <= last_reg;
            res_row_reg   <= last_reg ? cent_row_reg : '0;
            res_col_reg   <= last_reg ? cent_col_reg : '0;
            res_count_reg <= last_reg ? total_reg : '0;
        end
    end

    assign res_valid    = res_valid_reg;
    assign mask         = res_mask_reg;
    assign frame_done   = res_done_reg;
    assign centroid_row = ckmc_pkg::COORD_W'(res_row_reg);
    assign centroid_col = ckmc_pkg::COORD_W'(res_col_reg);
    assign pixel_count  = res_count_reg;

endmodule

// ===== rtl/core/ckmc_checker.sv =====
// Port-level checks for color_key_mask_centroid, attached by bind.
// Depends on ckmc_pkg for port widths.
module ckmc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                mode,
    input logic [ckmc_pkg::IDX_PORT_W-1:0]     entry_index,
    input logic [ckmc_pkg::CHAN_W-1:0]         blue,
    input logic [ckmc_pkg::CHAN_W-1:0]         green,
    input logic [ckmc_pkg::CHAN_W-1:0]         red,
    input logic [ckmc_pkg::COORD_W-1:0]        row,
    input logic [ckmc_pkg::COORD_W-1:0]        col,
    input logic                                last_of_frame,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic                                mask,
    input logic                                frame_done,
    input logic [ckmc_pkg::COORD_W-1:0]        centroid_row,
    input logic [ckmc_pkg::COORD_W-1:0]        centroid_col,
    input logic [ckmc_pkg::COUNT_W-1:0]        pixel_count
);

    // hold a waiting request until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(mode) && $stable(entry_index)
            && $stable(blue) && $stable(green) && $stable(red) && $stable(row)
            && $stable(col) && $stable(last_of_frame))
    else $error("waiting request changed");

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mask) && $stable(frame_done)
            && $stable(centroid_row) && $stable(centroid_col) && $stable(pixel_count))
    else $error("stalled result changed");

    // one request at a time: drop ready right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("ready held after accepted request");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_done |-> (pixel_count == '0) && (centroid_row == '0)
            && (centroid_col == '0))
    else $error("frame fields set on a result that closes no frame");

    // a matching last pixel is itself counted
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done && mask |-> (pixel_count != '0))
    else $error("matched last pixel missing from frame count");

endmodule

bind color_key_mask_centroid ckmc_checker u_ckmc_checker (.*);
